>>> rtl/core/pfal_pkg.sv
// ---------------------------------------------------------------------------
// pfal_pkg
// Shared sizes, codes, types and helpers for the node pool allocator.
// ---------------------------------------------------------------------------
package pfal_pkg;

    localparam int NODES     = 16;
    localparam int ADDR_W    = $clog2(NODES);
    localparam int LINK_W    = $clog2(NODES + 1);
    localparam int CNT_W     = $clog2(NODES + 1);
    localparam int DATA_W    = 32;
    localparam int IDX_OUT_W = 4;
    localparam int STAT_W    = 2;

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [LINK_W-1:0]    t_link;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [IDX_OUT_W-1:0] t_idx;
    typedef logic [STAT_W-1:0]    t_status;

    localparam t_link LINK_NULL = t_link'(NODES);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    // memory port bundle: one read address, one write port per array
    typedef struct packed {
        t_addr rd_addr;
        logic  lk_we;
        t_addr lk_waddr;
        t_link lk_wdata;
        logic  dt_we;
        t_addr dt_waddr;
        t_data dt_wdata;
    } t_mem_req;

    typedef struct packed {
        t_link link;
        t_data data;
    } t_mem_rsp;

    function automatic logic is_null(input t_link l);
        return l >= LINK_NULL;
    endfunction

    function automatic t_addr to_addr(input t_link l);
        return l[ADDR_W-1:0];
    endfunction

    function automatic t_idx to_idx(input t_link l);
        return t_idx'(l);
    endfunction

endpackage

>>> rtl/core/pfal_if.sv
// ---------------------------------------------------------------------------
// pfal_if
// Valid/ready channels for commands in and results out.
// ---------------------------------------------------------------------------
interface pfal_req_if import pfal_pkg::*;;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface pfal_rsp_if import pfal_pkg::*;;
    logic    valid;
    logic    ready;
    t_status status;
    t_idx    node_index;

    modport source (output valid, output status, output node_index, input ready);
    modport sink   (input valid, input status, input node_index, output ready);
endinterface

>>> rtl/core/pool_free_and_active_list.sv
// ---------------------------------------------------------------------------
// pool_free_and_active_list
// Fixed pool of nodes on a LIFO free list and an active list; insert at the
// front, remove the first node holding a value.
// ---------------------------------------------------------------------------
//  port    dir  transaction     payload
//  i_req   in   command         cmd (0 insert, 1 remove), value (32b signed)
//  o_rsp   out  result          status (0 ok, 1 full, 2 not found), node_index
//
//  Insert: S_INS fills the node, S_PUT loads the result; a full pool goes
//  straight to S_PUT. Remove: one link memory read per node walked (at most
//  NODES), plus S_FREE if it has a predecessor (link memory has one write
//  port). After reset a sweep over all NODES entries initializes the link
//  memory; i_req.ready stays low until it ends. One command is in flight at
//  a time; a result held in the output register stalls only the next finish.
// ---------------------------------------------------------------------------
module pool_free_and_active_list import pfal_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfal_req_if.sink   i_req,
    pfal_rsp_if.source o_rsp
);

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;

    pfal_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem_req (mem_req),
        .i_mem_rsp (mem_rsp)
    );

    pfal_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

endmodule

>>> rtl/core/pfal_mem.sv
// ---------------------------------------------------------------------------
// pfal_mem
// Link and data arrays of the pool, one registered read port each,
// one write port each.
// ---------------------------------------------------------------------------
module pfal_mem import pfal_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    t_link r_link_mem [NODES];
    t_data r_data_mem [NODES];
    t_link r_rd_link;
    t_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.lk_we) begin
            r_link_mem[i_req.lk_waddr] <= i_req.lk_wdata;
        end
        r_rd_link <= r_link_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.dt_we) begin
            r_data_mem[i_req.dt_waddr] <= i_req.dt_wdata;
        end
        r_rd_data <= r_data_mem[i_req.rd_addr];
    end

    assign o_rsp.link = r_rd_link;
    assign o_rsp.data = r_rd_data;

endmodule

>>> rtl/core/pfal_ctrl.sv
// ---------------------------------------------------------------------------
// pfal_ctrl
// Sequencer: link init sweep, insert, list walk with unlink, result register.
// ---------------------------------------------------------------------------
module pfal_ctrl import pfal_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pfal_req_if.sink       i_req,
    pfal_rsp_if.source     o_rsp,
    output t_mem_req       o_mem_req,
    input  t_mem_rsp       i_mem_rsp
);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_INS, S_WALK, S_FREE, S_PUT
    } t_state;

    t_state  r_state,       n_state;
    t_addr   r_init,        n_init;
    t_data   r_value,       n_value;
    t_link   r_cur,         n_cur;
    t_link   r_prev,        n_prev;
    t_cnt    r_steps,       n_steps;
    t_link   r_free_head,   n_free_head;
    t_link   r_active_head, n_active_head;
    t_status r_res_status,  n_res_status;
    t_idx    r_res_idx,     n_res_idx;
    logic    r_ovalid,      n_ovalid;
    t_status r_ostatus,     n_ostatus;
    t_idx    r_oidx,        n_oidx;
    t_mem_req mem_req;

    always_comb begin
        n_state       = r_state;
        n_init        = r_init;
        n_value       = r_value;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_steps       = r_steps;
        n_free_head   = r_free_head;
        n_active_head = r_active_head;
        n_res_status  = r_res_status;
        n_res_idx     = r_res_idx;
        n_ovalid      = r_ovalid & ~o_rsp.ready;
        n_ostatus     = r_ostatus;
        n_oidx        = r_oidx;
        mem_req       = '0;
        mem_req.rd_addr = to_addr(r_cur);

        unique case (r_state)
            S_INIT: begin
                // entry i links to i+1; the last one gets the null code
                mem_req.lk_we    = 1'b1;
                mem_req.lk_waddr = r_init;
                mem_req.lk_wdata = t_link'(r_init) + t_link'(1);
                n_init           = r_init + t_addr'(1);
                if (r_init == t_addr'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_value = t_data'(i_req.value);
                    if (i_req.cmd == CMD_INSERT) begin
                        if (is_null(r_free_head)) begin
                            n_res_status = ST_FULL;
                            n_res_idx    = '0;
                            n_state      = S_PUT;
                        end else begin
                            mem_req.rd_addr = to_addr(r_free_head);
                            n_cur           = r_free_head;
                            n_state         = S_INS;
                        end
                    end else begin
                        if (is_null(r_active_head)) begin
                            n_res_status = ST_NOT_FOUND;
                            n_res_idx    = '0;
                            n_state      = S_PUT;
                        end else begin
                            mem_req.rd_addr = to_addr(r_active_head);
                            n_cur           = r_active_head;
                            n_prev          = LINK_NULL;
                            n_steps         = t_cnt'(1);
                            n_state         = S_WALK;
                        end
                    end
                end
            end
            S_INS: begin
                n_free_head      = i_mem_rsp.link;
                mem_req.lk_we    = 1'b1;
                mem_req.lk_waddr = to_addr(r_cur);
                mem_req.lk_wdata = r_active_head;
                mem_req.dt_we    = 1'b1;
                mem_req.dt_waddr = to_addr(r_cur);
                mem_req.dt_wdata = r_value;
                n_active_head    = r_cur;
                n_res_status     = ST_OK;
                n_res_idx        = to_idx(r_cur);
                n_state          = S_PUT;
            end
            S_WALK: begin
                // read data belongs to r_cur; next read issues straight off its link
                if (i_mem_rsp.data == r_value) begin
                    if (is_null(r_prev)) begin
                        n_active_head    = i_mem_rsp.link;
                        mem_req.lk_we    = 1'b1;
                        mem_req.lk_waddr = to_addr(r_cur);
                        mem_req.lk_wdata = r_free_head;
                        n_free_head      = r_cur;
                        n_res_status     = ST_OK;
                        n_res_idx        = to_idx(r_cur);
                        n_state          = S_PUT;
                    end else begin
                        mem_req.lk_we    = 1'b1;
                        mem_req.lk_waddr = to_addr(r_prev);
                        mem_req.lk_wdata = i_mem_rsp.link;
                        n_state          = S_FREE;
                    end
                end else if (is_null(i_mem_rsp.link) || r_steps == t_cnt'(NODES)) begin
                    n_res_status = ST_NOT_FOUND;
                    n_res_idx    = '0;
                    n_state      = S_PUT;
                end else begin
                    mem_req.rd_addr = to_addr(i_mem_rsp.link);
                    n_prev          = r_cur;
                    n_cur           = i_mem_rsp.link;
                    n_steps         = r_steps + t_cnt'(1);
                end
            end
            S_FREE: begin
                mem_req.lk_we    = 1'b1;
                mem_req.lk_waddr = to_addr(r_cur);
                mem_req.lk_wdata = r_free_head;
                n_free_head      = r_cur;
                n_res_status     = ST_OK;
                n_res_idx        = to_idx(r_cur);
                n_state          = S_PUT;
            end
            S_PUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_res_status;
                    n_oidx    = r_res_idx;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_init        <= '0;
            r_free_head   <= '0;
            r_active_head <= LINK_NULL;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_init        <= n_init;
            r_free_head   <= n_free_head;
            r_active_head <= n_active_head;
            r_ovalid      <= n_ovalid;
            r_value       <= n_value;
            r_cur         <= n_cur;
            r_prev        <= n_prev;
            r_steps       <= n_steps;
            r_res_status  <= n_res_status;
            r_res_idx     <= n_res_idx;
            r_ostatus     <= n_ostatus;
            r_oidx        <= n_oidx;
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_ostatus;
    assign o_rsp.node_index = r_oidx;
    assign o_mem_req        = mem_req;

endmodule

>>> rtl/core/pfal_chk.sv
// ---------------------------------------------------------------------------
// pfal_chk
// Port-level checks on the pool allocator, bound to the top level.
// ---------------------------------------------------------------------------
module pfal_chk import pfal_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_req_valid,
    input logic    i_req_ready,
    input logic    i_rsp_valid,
    input logic    i_rsp_ready,
    input t_status i_rsp_status,
    input t_idx    i_rsp_node_index
);

    logic       req_xfer;
    logic       rsp_xfer;
    logic [1:0] r_outstanding;

    assign req_xfer = i_req_valid && i_req_ready;
    assign rsp_xfer = i_rsp_valid && i_rsp_ready;

    // commands accepted but results not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + 2'(req_xfer) - 2'(rsp_xfer);
        end
    end

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_OK || i_rsp_status == ST_FULL ||
                         i_rsp_status == ST_NOT_FOUND))
        else $error("illegal status code");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_OK) |-> (i_rsp_node_index == '0))
        else $error("node index nonzero on failed result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> !i_req_ready)
        else $error("second command taken while one is in flight");

    a_no_orphan_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_xfer |-> (r_outstanding != 2'd0))
        else $error("result without a command");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outstanding == 2'd2) |-> !i_req_ready)
        else $error("more than two transactions outstanding");

endmodule

bind pool_free_and_active_list pfal_chk u_pfal_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_node_index (o_rsp.node_index)
);
